/* src/hpfm_pkg.sv */
// hpfm_pkg: shared types and constants for the hysteresis period and frequency meter
// used by hpfm_ctrl, hpfm_dp and hysteresis_period_frequency_meter; no dependencies
`default_nettype none

package hpfm_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int THRESH_W    = 12;
    localparam int TIME_W      = 32;
    localparam int FREQ_W      = 28;

    // only the low SAMPLE_BITS bits of a sample take part in the compares
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic [THRESH_W-1:0] THRESH_LOW_RST  = THRESH_W'(2000);
    localparam logic [THRESH_W-1:0] THRESH_HIGH_RST = THRESH_W'(2100);

    // 1e6 Hz * 256 for the Q20.8 result
    localparam logic [FREQ_W-1:0] FREQ_SCALE_Q8 = FREQ_W'(256000000);

    // one quotient bit per divider step
    localparam int DIV_STEPS = FREQ_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    // register map
    localparam int ADDR_W = 3;
    localparam logic REG_THRESH_LOW  = 1'b0;
    localparam logic REG_THRESH_HIGH = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   time_us;
    } t_in;

    typedef struct packed {
        logic [TIME_W-1:0] period_len;
        logic [FREQ_W-1:0] freq_q8;
    } t_out;

    typedef struct packed {
        logic cap_start;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_low;
        logic is_high;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* src/hysteresis_period_frequency_meter.sv */
// hysteresis_period_frequency_meter: top level with threshold registers on an APB-style port
// depends on hpfm_pkg, hpfm_ctrl and hpfm_dp
// throughput: one sample per cycle while o_in_stall is low; a closing sample stalls the
//   input through the divider steps and the load into the output register, which waits
//   until that register is free; the result beat is valid once the register is loaded
// reset: synchronous active low; thresholds return to 2000 and 2100, sequencer to first phase
`default_nettype none

module hysteresis_period_frequency_meter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire hpfm_pkg::t_in               i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output hpfm_pkg::t_out                   o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hpfm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import hpfm_pkg::*;

    logic [THRESH_W-1:0] r_thresh_low;
    logic [THRESH_W-1:0] r_thresh_high;
    logic                cfg_wr;
    logic                reg_sel;
    t_cmd                cmd;
    t_stat               stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh_low  <= THRESH_LOW_RST;
            r_thresh_high <= THRESH_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_THRESH_LOW:  r_thresh_low  <= pwdata[THRESH_W-1:0];
                REG_THRESH_HIGH: r_thresh_high <= pwdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_THRESH_LOW:  prdata = 32'(r_thresh_low);
            REG_THRESH_HIGH: prdata = 32'(r_thresh_high);
            default:         prdata = '0;
        endcase
    end

    hpfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hpfm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_thresh_low  (r_thresh_low),
        .i_thresh_high (r_thresh_high),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out         (o_out),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall)
    );

endmodule

`default_nettype wire

/* src/hpfm_dp.sv */
// hpfm_dp: threshold compares, start timestamp, serial restoring divider and output register
// depends on hpfm_pkg; driven by commands from hpfm_ctrl
`default_nettype none

module hpfm_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hpfm_pkg::t_in               i_in,
    input  wire logic [hpfm_pkg::THRESH_W-1:0] i_thresh_low,
    input  wire logic [hpfm_pkg::THRESH_W-1:0] i_thresh_high,
    input  wire hpfm_pkg::t_cmd              i_cmd,
    output hpfm_pkg::t_stat                  o_stat,
    output hpfm_pkg::t_out                   o_out,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall
);
    import hpfm_pkg::*;

    logic [SAMPLE_W-1:0] sample_m;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   r_period;
    logic [TIME_W-1:0]   r_rem;
    logic [FREQ_W-1:0]   r_quo;
    logic [TIME_W:0]     shifted;
    logic [TIME_W:0]     diff;
    logic                ge;
    logic                r_out_valid;
    t_out                r_out;

    assign sample_m = i_in.sample & SAMPLE_MASK;

    always_comb begin
        o_stat.is_low   = sample_m <= i_thresh_low;
        o_stat.is_high  = sample_m >= i_thresh_high;
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    // restoring step: bring the next dividend bit down, subtract if it fits
    assign shifted = {r_rem, r_quo[FREQ_W-1]};
    assign diff    = shifted - {1'b0, r_period};
    assign ge      = !diff[TIME_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_start) begin
            r_start <= i_in.time_us;
        end
        if (i_cmd.div_load) begin
            r_period <= i_in.time_us - r_start;
            r_rem    <= '0;
            r_quo    <= FREQ_SCALE_Q8;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            r_quo <= {r_quo[FREQ_W-2:0], ge};
        end
        if (i_cmd.out_load) begin
            r_out.period_len <= r_period;
            r_out.freq_q8    <= (r_period == '0) ? '0 : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* src/hpfm_ctrl.sv */
// hpfm_ctrl: hysteresis phase sequencer and divider step control
// depends on hpfm_pkg; commands hpfm_dp and reads its status
`default_nettype none

module hpfm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire hpfm_pkg::t_stat  i_stat,
    output hpfm_pkg::t_cmd        o_cmd
);
    import hpfm_pkg::*;

    typedef enum logic [1:0] {
        S_IN,
        S_DIV,
        S_LOAD
    } t_state;

    typedef enum logic [1:0] {
        PH_LOW0,
        PH_HIGH0,
        PH_LOW1,
        PH_HIGH1
    } t_phase;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic            accept;

    assign o_in_stall = (r_state != S_IN);
    assign accept     = i_in_valid && (r_state == S_IN);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IN: begin
                if (accept) begin
                    unique case (r_phase)
                        PH_LOW0: begin
                            if (i_stat.is_low) n_phase = PH_HIGH0;
                        end
                        PH_HIGH0: begin
                            if (i_stat.is_high) begin
                                o_cmd.cap_start = 1'b1;
                                n_phase         = PH_LOW1;
                            end
                        end
                        PH_LOW1: begin
                            if (i_stat.is_low) n_phase = PH_HIGH1;
                        end
                        PH_HIGH1: begin
                            // second rising crossing closes the period
                            if (i_stat.is_high) begin
                                o_cmd.div_load = 1'b1;
                                n_phase        = PH_LOW0;
                                n_cnt          = '0;
                                n_state        = S_DIV;
                            end
                        end
                        default: n_phase = PH_LOW0;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IN;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_phase <= PH_LOW0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* bench/hpfm_checker.sv */
// hpfm_checker: predicts the period meter's measurements from accepted sample beats and
// register writes, and compares them with the result beats; depends on hpfm_pkg only
module hpfm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  hpfm_pkg::t_in               i_in_beat,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  hpfm_pkg::t_out              i_out_beat,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [hpfm_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hpfm_pkg::*;

    typedef enum logic [1:0] {
        WAIT_LOW_A,
        WAIT_HIGH_A,
        WAIT_LOW_B,
        WAIT_HIGH_B
    } seq_phase_e;

    seq_phase_e          seq_phase;
    logic [THRESH_W-1:0] low_lvl;
    logic [THRESH_W-1:0] high_lvl;
    logic [TIME_W-1:0]   start_us;
    t_out                meas_q[$];
    t_out                want;
    logic [ADDR_W-1:0]   reg_idx;
    int                  fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one sample moves the sequencer at most one phase
    task automatic take_sample(input t_in beat);
        logic [SAMPLE_W-1:0] s;
        logic [TIME_W-1:0]   span;
        t_out                m;
        s = beat.sample & SAMPLE_MASK;
        case (seq_phase)
            WAIT_LOW_A: begin
                if (s <= low_lvl) seq_phase = WAIT_HIGH_A;
            end
            WAIT_HIGH_A: begin
                if (s >= high_lvl) begin
                    start_us  = beat.time_us;
                    seq_phase = WAIT_LOW_B;
                end
            end
            WAIT_LOW_B: begin
                if (s <= low_lvl) seq_phase = WAIT_HIGH_B;
            end
            default: begin
                if (s >= high_lvl) begin
                    span         = beat.time_us - start_us;
                    m.period_len = span;
                    m.freq_q8    = (span == '0) ? '0 : FREQ_W'(32'(FREQ_SCALE_Q8) / span);
                    meas_q.push_back(m);
                    seq_phase = WAIT_LOW_A;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_phase = WAIT_LOW_A;
            low_lvl   = THRESH_LOW_RST;
            high_lvl  = THRESH_HIGH_RST;
            start_us  = '0;
            meas_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (meas_q.size() == 0) begin
                    $error("result beat with nothing pending: period_len %0d freq_q8 %0d",
                           i_out_beat.period_len, i_out_beat.freq_q8);
                    fails++;
                end else begin
                    want = meas_q.pop_front();
                    if (i_out_beat.period_len !== want.period_len) begin
                        $error("period_len: expected %0d, got %0d",
                               want.period_len, i_out_beat.period_len);
                        fails++;
                    end
                    if (i_out_beat.freq_q8 !== want.freq_q8) begin
                        $error("freq_q8: expected %0d, got %0d",
                               want.freq_q8, i_out_beat.freq_q8);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) take_sample(i_in_beat);
            // a write lands for the next sample and leaves the sequencer alone
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = i_paddr >> 2;
                if (reg_idx == ADDR_W'(REG_THRESH_LOW))
                    low_lvl = i_pwdata[THRESH_W-1:0];
                else if (reg_idx == ADDR_W'(REG_THRESH_HIGH))
                    high_lvl = i_pwdata[THRESH_W-1:0];
            end
        end
        o_fail_count <= fails;
        o_pending    <= meas_q.size();
    end

endmodule

/* bench/tb_top.sv */
// tb_top: stimulus and verdict for hysteresis_period_frequency_meter
// depends on hpfm_pkg, the block's RTL and hpfm_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hpfm_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEQ_PER_PHASE = 20;
    localparam int RAND_PHASES   = 6;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    localparam logic [ADDR_W-1:0] LOW_ADDR  = ADDR_W'(REG_THRESH_LOW) << 2;
    localparam logic [ADDR_W-1:0] HIGH_ADDR = ADDR_W'(REG_THRESH_HIGH) << 2;

    typedef enum {LVL_LOW, LVL_MID, LVL_HIGH, LVL_ANY} lvl_kind_e;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in               in_beat;
    logic              out_valid;
    logic              out_stall;
    t_out              out_beat;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int          fail_count;
    int          meas_pending;
    int          tx_idle_pct = 25;
    int          rx_idle_pct = 60;
    bit          hold_req = 0;
    int          hold_left = 0;
    int          lvl_low = 2000;
    int          lvl_high = 2100;
    logic [31:0] now_us = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    hysteresis_period_frequency_meter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    hpfm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (meas_pending)
    );

    // setup then access; the idle cycle after keeps psel from being re-driven in one step
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // junk in the upper bits checks the 12-bit masking
    task automatic set_levels(input int lo, input int hi);
        logic [31:0] word;
        word        = $urandom;
        word[11:0]  = lo[11:0];
        apb_write(LOW_ADDR, word);
        word        = $urandom;
        word[11:0]  = hi[11:0];
        apb_write(HIGH_ADDR, word);
        lvl_low  = lo;
        lvl_high = hi;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
        t_in beat;
        beat.sample  = s;
        beat.time_us = t;
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge i_clk); while (in_stall);
    endtask

    // drop valid and wait out any measurement still in the divider or the output
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (meas_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_level(input lvl_kind_e kind);
        case (kind)
            LVL_LOW:  return SAMPLE_W'($urandom_range(lvl_low, 0));
            LVL_HIGH: return SAMPLE_W'($urandom_range(SAMPLE_MAX, lvl_high));
            LVL_MID: begin
                if (lvl_high > lvl_low + 1)
                    return SAMPLE_W'($urandom_range(lvl_high - 1, lvl_low + 1));
                return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
            end
            default:  return SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        endcase
    endfunction

    // mostly short steps, some repeats, now and then a big jump that wraps
    function automatic logic [31:0] next_stamp();
        int          r;
        logic [31:0] stride;
        r = $urandom_range(99);
        if (r < 10)      stride = '0;
        else if (r < 80) stride = $urandom_range(5000, 1);
        else if (r < 95) stride = $urandom_range(1 << 20, 0);
        else             stride = $urandom;
        now_us += stride;
        return now_us;
    endfunction

    task automatic run_period();
        lvl_kind_e order[4] = '{LVL_LOW, LVL_HIGH, LVL_LOW, LVL_HIGH};
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(2, 1)) send_sample(pick_level(LVL_MID), next_stamp());
            send_sample(pick_level(order[k]), next_stamp());
        end
    endtask

    // receiver: random stall, or a long hold-off when asked
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int lo;
        int n;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // equal-to-threshold samples, in-band samples in every phase but the first, zero period
        send_sample(0, 100);
        send_sample(2099, 150);
        send_sample(4095, 1000);
        send_sample(2001, 1001);
        send_sample(2000, 1002);
        send_sample(2099, 1003);
        send_sample(2100, 1000);
        // timestamp wraps between start and end
        send_sample(2050, 0);
        send_sample(2000, 32'hFFFF_FFF0);
        send_sample(2100, 32'hFFFF_FFF0);
        send_sample(0, 3);
        send_sample(4095, 32'h0000_0010);
        // shortest period gives the largest frequency
        send_sample(0, 7);
        send_sample(4095, 5);
        send_sample(0, 5);
        send_sample(4095, 6);
        // longest period truncates to zero
        send_sample(0, 0);
        send_sample(4095, 0);
        send_sample(0, 0);
        send_sample(4095, 32'hFFFF_FFFF);
        // crossed levels: one sample is both low and high but moves one phase
        settle_idle();
        set_levels(3000, 1000);
        send_sample(2000, 10);
        send_sample(2000, 20);
        send_sample(2000, 40);
        send_sample(2000, 80);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle_idle();
            case (ph)
                0: set_levels(2000, 2100);
                1: set_levels(0, SAMPLE_MAX);
                2: set_levels(SAMPLE_MAX, 0);
                3: begin
                    lo = $urandom_range(4000, 0);
                    set_levels(lo, $urandom_range(SAMPLE_MAX, lo + 1));
                end
                4: set_levels(1000, 3000);
                default: set_levels($urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0));
            endcase
            tx_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 60 : 0;
            rx_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 25 : 0;
            // output blocked while samples keep coming, so the block backs up
            if (ph == 4) hold_req = 1;
            n = 0;
            while (n < SEQ_PER_PHASE) begin
                if ($urandom_range(99) < 80) begin
                    run_period();
                    n++;
                end else begin
                    repeat ($urandom_range(3, 1)) send_sample(pick_level(LVL_ANY), next_stamp());
                end
            end
        end

        settle_idle();
        if (meas_pending != 0)
            $error("%0d measurements never came out", meas_pending);
        if (fail_count == 0 && meas_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
